[rtl/bacs_pkg.sv]
// Shared types, widths and constants for the BPSK AWGN channel slicer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bacs_pkg;

  localparam int UNIFORM_BITS     = 16;
  localparam int SAMPLE_FRAC_BITS = 12;
  localparam int RX_BITS          = 20;
  localparam int SIGMA_W          = 16;

  // log2 / radius path
  localparam int LOG_FRAC  = 24;
  localparam int LOG_STEPS = LOG_FRAC;
  localparam int N_W       = UNIFORM_BITS + 1;
  localparam int E_W       = $clog2(UNIFORM_BITS + 1);
  localparam int MANT_W    = 32;
  localparam int LV_W      = E_W + LOG_FRAC;
  localparam int RQ_W      = LV_W + 1;
  localparam int V_W       = RQ_W + LOG_FRAC;
  localparam int SQ_W      = V_W + (V_W % 2);
  localparam int RAD_W     = SQ_W / 2;

  // angle path, Q30
  localparam int Q_W          = 30;
  localparam int MAG_W        = Q_W + 1;
  localparam int X_W          = Q_W;
  localparam int HORNER_STEPS = 7;

  // output path
  localparam int G_W      = RAD_W + 1;
  localparam int PROD_W   = G_W + SIGMA_W;
  localparam int NOISE_SH = 38 - SAMPLE_FRAC_BITS;
  localparam int NOISE_W  = PROD_W + 1 - NOISE_SH;
  localparam int SMP_W    = ((NOISE_W > SAMPLE_FRAC_BITS + 1) ? NOISE_W
                                                           : SAMPLE_FRAC_BITS + 1) + 2;

  localparam logic [MAG_W-1:0]   Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0]        TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd16384;

  // register select, paddr[2]
  localparam logic REG_NOISE_SIGMA = 1'b0;

  // Horner divisors and floor(2^32/d) reciprocals, one per step.
  // sin skips its first step; that slot only holds a harmless value.
  localparam logic [7:0] COS_DIV [HORNER_STEPS] =
    '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_REC [HORNER_STEPS] =
    '{32'd23598721, 32'd32537631, 32'd47721858, 32'd76695844,
      32'd143165576, 32'd357913941, 32'd2147483648};
  localparam logic [7:0] SIN_DIV [HORNER_STEPS] =
    '{8'd2, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SIN_REC [HORNER_STEPS] =
    '{32'd2147483648, 32'd27531841, 32'd39045157, 32'd59652323,
      32'd102261126, 32'd214748364, 32'd715827882};

  typedef struct packed {
    logic        tx_bit;
    logic [15:0] uniform_a;
    logic [15:0] uniform_b;
  } in_word_t;

  typedef struct packed {
    logic signed [19:0] rx_sample;
    logic               decoded_bit;
    logic               bit_error;
  } out_word_t;

  typedef struct packed {
    logic             tx_bit;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } ang_t;

  typedef struct packed {
    ang_t                    ang;
    logic [UNIFORM_BITS-1:0] uniform_a;
  } trig_out_t;

  typedef struct packed {
    ang_t            ang;
    logic [RQ_W-1:0] rq;
  } log_out_t;

  typedef struct packed {
    ang_t             ang;
    logic [RAD_W-1:0] rad;
  } sqrt_out_t;

endpackage

[rtl/bacs_trig.sv]
// Angle pipeline: quadrant fold, octant fold and Taylor cos/sin by Horner.
// Depends on bacs_pkg.
`timescale 1ns / 1ps

module bacs_trig (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  bacs_pkg::in_word_t   in_word,
  output logic                 out_vld,
  output bacs_pkg::trig_out_t  out_word
);
  import bacs_pkg::*;

  typedef struct packed {
    logic                    tx_bit;
    logic [UNIFORM_BITS-1:0] uniform_a;
    logic                    neg;
    logic                    is_sin;
    logic [X_W-1:0]          x;
    logic [X_W-1:0]          x2;
    logic [MAG_W-1:0]        t;
    logic [Q_W-1:0]          p;
    logic [Q_W-1:0]          qe;
  } hstage_t;

  hstage_t s0_r, s1_r, s2_r, s0_nxt, s1_nxt, s2_nxt;
  logic    v0_r, v1_r, v2_r;
  hstage_t a_r [HORNER_STEPS];
  hstage_t b_r [HORNER_STEPS];
  hstage_t c_r [HORNER_STEPS];
  hstage_t a_nxt [HORNER_STEPS];
  hstage_t b_nxt [HORNER_STEPS];
  hstage_t c_nxt [HORNER_STEPS];
  logic [HORNER_STEPS-1:0] av_r, bv_r, cv_r;
  trig_out_t f_r, f_nxt;
  logic      fv_r;

  logic [UNIFORM_BITS:0] nb;
  logic [31:0]           phase;
  logic [1:0]            quad;
  logic [MAG_W-1:0]      rr, rp, arg;
  logic                  sel_sin;
  logic [X_W+30:0]       xprod;
  logic [2*X_W-1:0]      xsq;
  logic [X_W+MAG_W-1:0]  xt;

  // front: fold the phase into the first octant
  always_comb begin
    nb      = {1'b0, in_word.uniform_b[UNIFORM_BITS-1:0]} + 1'b1;
    phase   = 32'({32'd0, nb} << (32 - UNIFORM_BITS));
    quad    = phase[31:30];
    rr      = {1'b0, phase[29:0]};
    rp      = quad[0] ? (Q30_ONE - rr) : rr;
    sel_sin = rp > (Q30_ONE >> 1);
    arg     = sel_sin ? (Q30_ONE - rp) : rp;

    s0_nxt           = '0;
    s0_nxt.tx_bit    = in_word.tx_bit;
    s0_nxt.uniform_a = in_word.uniform_a[UNIFORM_BITS-1:0];
    s0_nxt.neg       = (quad == 2'd1) || (quad == 2'd2);
    s0_nxt.is_sin    = sel_sin;
    s0_nxt.x         = arg[X_W-1:0];

    s1_nxt   = s0_r;
    xprod    = (X_W+31)'(s0_r.x) * (X_W+31)'(HALF_PI_Q30);
    s1_nxt.x = xprod[X_W+29:30];

    s2_nxt    = s1_r;
    xsq       = (2*X_W)'(s1_r.x) * (2*X_W)'(s1_r.x);
    s2_nxt.x2 = xsq[X_W+29:30];
    s2_nxt.t  = Q30_ONE;
  end

  // Horner steps: multiply, reciprocal multiply, correct and subtract
  always_comb begin
    hstage_t                src;
    logic [X_W+MAG_W-1:0]   pt;
    logic [Q_W+31:0]        pm;
    logic [31:0]            mv;
    logic [7:0]             dv;
    logic [Q_W+7:0]         qd;
    logic [Q_W+7:0]         rem;
    logic [Q_W-1:0]         q;
    logic                   skip;
    for (int j = 0; j < HORNER_STEPS; j++) begin
      if (j == 0) src = s2_r;
      else        src = c_r[j-1];
      a_nxt[j]   = src;
      pt         = (X_W+MAG_W)'(src.x2) * (X_W+MAG_W)'(src.t);
      a_nxt[j].p = pt[Q_W+29:30];

      b_nxt[j]    = a_r[j];
      mv          = a_r[j].is_sin ? SIN_REC[j] : COS_REC[j];
      pm          = (Q_W+32)'(a_r[j].p) * (Q_W+32)'(mv);
      b_nxt[j].qe = pm[Q_W+31:32];

      c_nxt[j] = b_r[j];
      dv       = b_r[j].is_sin ? SIN_DIV[j] : COS_DIV[j];
      skip     = b_r[j].is_sin && (j == 0);
      qd       = (Q_W+8)'(b_r[j].qe) * (Q_W+8)'(dv);
      rem      = (Q_W+8)'(b_r[j].p) - qd;
      q        = b_r[j].qe + Q_W'(rem >= (Q_W+8)'(dv));
      c_nxt[j].t = skip ? b_r[j].t : (Q30_ONE - MAG_W'(q));
    end
  end

  always_comb begin
    xt                = (X_W+MAG_W)'(c_r[HORNER_STEPS-1].x) *
                        (X_W+MAG_W)'(c_r[HORNER_STEPS-1].t);
    f_nxt.uniform_a   = c_r[HORNER_STEPS-1].uniform_a;
    f_nxt.ang.tx_bit  = c_r[HORNER_STEPS-1].tx_bit;
    f_nxt.ang.neg     = c_r[HORNER_STEPS-1].neg;
    f_nxt.ang.mag     = c_r[HORNER_STEPS-1].is_sin ? xt[X_W+MAG_W-1:30]
                                                   : c_r[HORNER_STEPS-1].t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      av_r <= '0;
      bv_r <= '0;
      cv_r <= '0;
      fv_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
      av_r <= {cv_r[HORNER_STEPS-2:0], v2_r};
      bv_r <= av_r;
      cv_r <= bv_r;
      fv_r <= cv_r[HORNER_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      for (int j = 0; j < HORNER_STEPS; j++) begin
        a_r[j] <= a_nxt[j];
        b_r[j] <= b_nxt[j];
        c_r[j] <= c_nxt[j];
      end
      f_r <= f_nxt;
    end
  end

  assign out_vld  = fv_r;
  assign out_word = f_r;

endmodule

[rtl/bacs_log.sv]
// Logarithm pipeline: leading-one normalize, one mantissa squaring per stage,
// then scale to -2 ln u1. Depends on bacs_pkg.
`timescale 1ns / 1ps

module bacs_log (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  bacs_pkg::trig_out_t  in_word,
  output logic                 out_vld,
  output bacs_pkg::log_out_t   out_word
);
  import bacs_pkg::*;

  typedef struct packed {
    ang_t                ang;
    logic [E_W-1:0]      e;
    logic [MANT_W-1:0]   m;
    logic [LOG_FRAC-1:0] f;
  } lstage_t;

  lstage_t l0_r, l0_nxt;
  logic    l0v_r;
  lstage_t q_r   [LOG_STEPS];
  lstage_t q_nxt [LOG_STEPS];
  logic [LOG_STEPS-1:0] qv_r;
  log_out_t o_r, o_nxt;
  logic     ov_r;

  logic [N_W-1:0]    n;
  logic [N_W+30:0]   nsh;
  logic [LV_W-1:0]   lv_e, lval;
  logic [LV_W+30:0]  rprod;

  always_comb begin
    n   = {1'b0, in_word.uniform_a} + 1'b1;
    nsh = {n, 31'b0};
    l0_nxt     = '0;
    l0_nxt.ang = in_word.ang;
    for (int i = 0; i < N_W; i++) begin
      if (n[i]) l0_nxt.e = E_W'(i);
    end
    l0_nxt.m = MANT_W'(nsh >> l0_nxt.e);
  end

  // each squaring yields one fraction bit of log2
  always_comb begin
    lstage_t            src;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]    s;
    for (int k = 0; k < LOG_STEPS; k++) begin
      if (k == 0) src = l0_r;
      else        src = q_r[k-1];
      sq = (2*MANT_W)'(src.m) * (2*MANT_W)'(src.m);
      s  = sq[2*MANT_W-1:MANT_W-1];
      q_nxt[k] = src;
      if (s[MANT_W]) begin
        q_nxt[k].m = s[MANT_W:1];
        q_nxt[k].f = {src.f[LOG_FRAC-2:0], 1'b1};
      end else begin
        q_nxt[k].m = s[MANT_W-1:0];
        q_nxt[k].f = {src.f[LOG_FRAC-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    lv_e      = LV_W'(UNIFORM_BITS) - LV_W'(q_r[LOG_STEPS-1].e);
    lval      = (lv_e << LOG_FRAC) - LV_W'(q_r[LOG_STEPS-1].f);
    rprod     = (LV_W+31)'(lval) * (LV_W+31)'(TWO_LN2_Q30);
    o_nxt.ang = q_r[LOG_STEPS-1].ang;
    o_nxt.rq  = rprod[RQ_W+29:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0v_r <= 1'b0;
      qv_r  <= '0;
      ov_r  <= 1'b0;
    end else if (adv) begin
      l0v_r <= in_vld;
      qv_r  <= {qv_r[LOG_STEPS-2:0], l0v_r};
      ov_r  <= qv_r[LOG_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l0_r <= l0_nxt;
      for (int k = 0; k < LOG_STEPS; k++) q_r[k] <= q_nxt[k];
      o_r <= o_nxt;
    end
  end

  assign out_vld  = ov_r;
  assign out_word = o_r;

endmodule

[rtl/bacs_sqrt.sv]
// Radius pipeline: floor square root, one result bit per stage.
// Depends on bacs_pkg.
`timescale 1ns / 1ps

module bacs_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  bacs_pkg::log_out_t   in_word,
  output logic                 out_vld,
  output bacs_pkg::sqrt_out_t  out_word
);
  import bacs_pkg::*;

  localparam int REM_W = RAD_W + 3;

  typedef struct packed {
    ang_t             ang;
    logic [SQ_W-1:0]  v;
    logic [RAD_W-1:0] root;
    logic [REM_W-1:0] rem;
  } sstage_t;

  sstage_t st_r   [RAD_W];
  sstage_t st_nxt [RAD_W];
  logic [RAD_W-1:0] sv_r;

  always_comb begin
    sstage_t          src;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    for (int i = 0; i < RAD_W; i++) begin
      if (i == 0) begin
        src.ang  = in_word.ang;
        src.v    = SQ_W'({in_word.rq, {LOG_FRAC{1'b0}}});
        src.root = '0;
        src.rem  = '0;
      end else begin
        src = st_r[i-1];
      end
      rem_sh = {src.rem[REM_W-3:0], src.v[SQ_W-1 -: 2]};
      trial  = REM_W'({src.root, 2'b01});
      st_nxt[i]     = src;
      st_nxt[i].v   = src.v << 2;
      if (rem_sh >= trial) begin
        st_nxt[i].rem  = rem_sh - trial;
        st_nxt[i].root = {src.root[RAD_W-2:0], 1'b1};
      end else begin
        st_nxt[i].rem  = rem_sh;
        st_nxt[i].root = {src.root[RAD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[RAD_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < RAD_W; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_vld      = sv_r[RAD_W-1];
  assign out_word.ang = st_r[RAD_W-1].ang;
  assign out_word.rad = st_r[RAD_W-1].root;

endmodule

[rtl/bacs_out.sv]
// Output pipeline: Gaussian magnitude, sigma scaling, rounding, symbol add,
// saturation and slicer. Depends on bacs_pkg.
`timescale 1ns / 1ps

module bacs_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_vld,
  input  bacs_pkg::sqrt_out_t           in_word,
  input  logic [bacs_pkg::SIGMA_W-1:0]  sigma,
  output logic                          out_vld,
  output bacs_pkg::out_word_t           out_word
);
  import bacs_pkg::*;

  localparam logic signed [SMP_W-1:0] ONE_S  = SMP_W'(1 << SAMPLE_FRAC_BITS);
  localparam logic signed [SMP_W-1:0] RX_MAX = SMP_W'((1 << (RX_BITS - 1)) - 1);
  localparam logic signed [SMP_W-1:0] RX_MIN = SMP_W'(-(1 << (RX_BITS - 1)));

  logic              tx0_r, neg0_r, tx1_r, neg1_r;
  logic [G_W-1:0]    g_r, g_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              v0_r, v1_r, ov_r;
  out_word_t         o_r, o_nxt;

  logic [RAD_W+MAG_W-1:0]   gm;
  logic [PROD_W:0]          rnd;
  logic [NOISE_W-1:0]       noise;
  logic signed [SMP_W-1:0]  sym, nz, smp, sat;

  always_comb begin
    gm       = (RAD_W+MAG_W)'(in_word.rad) * (RAD_W+MAG_W)'(in_word.ang.mag);
    g_nxt    = gm[G_W+29:30];
    prod_nxt = PROD_W'(g_r) * PROD_W'(sigma);

    // round half up to the sample fraction
    rnd   = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(1) << (NOISE_SH - 1));
    noise = rnd[PROD_W:NOISE_SH];
    nz    = $signed(SMP_W'(noise));
    sym   = tx1_r ? ONE_S : -ONE_S;
    smp   = neg1_r ? (sym - nz) : (sym + nz);
    if (smp > RX_MAX)      sat = RX_MAX;
    else if (smp < RX_MIN) sat = RX_MIN;
    else                   sat = smp;
    o_nxt.rx_sample   = RX_BITS'(sat);
    o_nxt.decoded_bit = sat > 0;
    o_nxt.bit_error   = (sat > 0) != tx1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      ov_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r    <= g_nxt;
      tx0_r  <= in_word.ang.tx_bit;
      neg0_r <= in_word.ang.neg;
      prod_r <= prod_nxt;
      tx1_r  <= tx0_r;
      neg1_r <= neg0_r;
      o_r    <= o_nxt;
    end
  end

  assign out_vld  = ov_r;
  assign out_word = o_r;

endmodule

[rtl/bpsk_awgn_channel_slicer.sv]
// Top level: BPSK symbol plus Box-Muller Gaussian noise, saturated, sliced.
// Depends on bacs_pkg, bacs_trig, bacs_log, bacs_sqrt, bacs_out.
//
//   port group   direction  handshake          word
//   in_*         input      in_valid/in_stall  in_word_t  (tx_bit, uniform_a, uniform_b)
//   out_*        output     out_valid/out_stall out_word_t (rx_sample, decoded_bit, bit_error)
//   APB          input      psel/penable/pready noise_sigma at paddr 0
//
// One word per clock while the output is not stalled; the pipe runs angle, log,
// square root (one bit per stage) and output sections in that order.
// Reset is synchronous, active low; it empties the pipe and loads sigma 1.0.
// A stalled output freezes the whole pipe and stalls the input in the same cycle.
`timescale 1ns / 1ps

module bpsk_awgn_channel_slicer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bacs_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bacs_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bacs_pkg::*;

  logic [SIGMA_W-1:0] sigma_r;
  logic               adv;
  logic               trig_vld, log_vld, sqrt_vld;
  trig_out_t          trig_word;
  log_out_t           log_word;
  sqrt_out_t          sqrt_word;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NOISE_SIGMA) ? {{(32-SIGMA_W){1'b0}}, sigma_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NOISE_SIGMA)) begin
      sigma_r <= pwdata[SIGMA_W-1:0];
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  bacs_trig u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_word  (in_data),
    .out_vld  (trig_vld),
    .out_word (trig_word)
  );

  bacs_log u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (trig_vld),
    .in_word  (trig_word),
    .out_vld  (log_vld),
    .out_word (log_word)
  );

  bacs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (log_vld),
    .in_word  (log_word),
    .out_vld  (sqrt_vld),
    .out_word (sqrt_word)
  );

  bacs_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (sqrt_vld),
    .in_word  (sqrt_word),
    .sigma    (sigma_r),
    .out_vld  (out_valid),
    .out_word (out_data)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  a_slicer_matches_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.decoded_bit == ($signed(out_data.rx_sample) > 0)))
    else $error("decoded bit disagrees with sample sign");

  a_sigma_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[2] == REG_NOISE_SIGMA))
      |=> (sigma_r == $past(pwdata[SIGMA_W-1:0])))
    else $error("noise_sigma write lost");

endmodule
